// ----- hdl/lpol_pkg.sv -----
// ----------------------------------------------------------------------------
// lpol_pkg
// shared types and codes for the lru page order list
// ----------------------------------------------------------------------------
package lpol_pkg;

  localparam int PAGE_W      = 52;
  localparam int COUNT_OUT_W = 4;

  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  typedef enum logic {
    KIND_TOUCH = 1'b0,
    KIND_EVICT = 1'b1
  } kind_t;

  // operation broadcast to every cell in the chain
  typedef struct packed {
    logic touch;
    logic evict;
    logic hit;
  } cell_ctrl_t;

endpackage

// ----- hdl/lpol_cell.sv -----
// ----------------------------------------------------------------------------
// lpol_cell
// one slot of the list: compares its page with the key, ripples the hit
// flag toward newer slots and takes its neighbor's page or the key
// ----------------------------------------------------------------------------
module lpol_cell import lpol_pkg::*; #(
  parameter int CW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] count,
  input  page_t         key,
  input  page_t         right_slot,
  input  logic          hit_in,
  output logic          hit_out,
  output page_t         slot,
  output page_t         slot_next
);

  logic in_list;
  logic has_behind;
  logic is_last;
  logic is_next;
  logic match;

  assign in_list    = CW'(IDX) < count;
  assign has_behind = CW'(IDX + 1) < count;
  assign is_last    = CW'(IDX + 1) == count;
  assign is_next    = CW'(IDX) == count;
  assign match      = in_list && (slot == key);
  assign hit_out    = hit_in || match;

  always_comb begin
    if (ctrl.touch && ctrl.hit && is_last) begin
      slot_next = key;
    end else if (ctrl.touch && !ctrl.hit && is_next) begin
      slot_next = key;
    end else if ((ctrl.evict || (ctrl.touch && hit_out)) && has_behind) begin
      slot_next = right_slot;
    end else begin
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ----- hdl/lru_page_order_list_top.sv -----
// ----------------------------------------------------------------------------
// lru_page_order_list_top
// lru ordered page list built as a chain of slot cells
// ----------------------------------------------------------------------------
// Holds up to DEPTH pages, oldest in cell 0. Every accepted item gives one
// result in the next cycle, and a new item is taken in every cycle while the
// result register is free or being emptied, so the rate is one item per
// cycle. The clock period is set by the key compare in all cells followed by
// the hit flag rippling through the DEPTH cells of the chain.
module lru_page_order_list_top import lpol_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  page_t      page_number,
  output logic       out_valid,
  input  logic       out_stall,
  output page_t      evicted_page,
  output logic       evicted_valid,
  output logic       insert_dropped,
  output page_t      oldest_page,
  output count_out_t stored_count,
  output logic       is_full,
  output logic       is_empty
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          any_hit;
  logic          evict_ok;
  logic          dropped;
  cell_ctrl_t    ctrl;
  logic          hit_chain [DEPTH+1];
  page_t         slot      [DEPTH+1];
  page_t         slot_next [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign hit_chain[0] = 1'b0;
  assign slot[DEPTH]  = '0;
  assign any_hit      = hit_chain[DEPTH];

  assign ctrl.touch = accept && (kind_t'(kind) == KIND_TOUCH);
  assign ctrl.evict = accept && (kind_t'(kind) == KIND_EVICT);
  assign ctrl.hit   = any_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lpol_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .key        (page_number),
      .right_slot (slot[i+1]),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .slot       (slot[i]),
      .slot_next  (slot_next[i])
    );
  end

  assign evict_ok = ctrl.evict && (count != '0);
  assign dropped  = ctrl.touch && !any_hit && (count == CW'(DEPTH));

  always_comb begin
    count_next = count;
    if (ctrl.touch && !any_hit && (count != CW'(DEPTH))) begin
      count_next = count + CW'(1);
    end else if (evict_ok) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evicted_page   <= evict_ok ? slot[0] : '0;
      evicted_valid  <= evict_ok;
      insert_dropped <= dropped;
      oldest_page    <= (count_next != '0) ? slot_next[0] : '0;
      stored_count   <= COUNT_OUT_W'(count_next);
      is_full        <= count_next == CW'(DEPTH);
      is_empty       <= count_next == '0;
    end
  end

endmodule

// ----- hdl/lpol_checker.sv -----
// ----------------------------------------------------------------------------
// lpol_checker
// port level checks for the lru page order list
// ----------------------------------------------------------------------------
module lpol_checker import lpol_pkg::*; #(
  parameter int DEPTH = 8
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input page_t      evicted_page,
  input logic       evicted_valid,
  input logic       insert_dropped,
  input page_t      oldest_page,
  input count_out_t stored_count,
  input logic       is_full,
  input logic       is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item lost while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> stored_count == '0 && oldest_page == '0 && !is_full)
    else $error("empty list shows pages");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && insert_dropped |-> is_full && !evicted_valid)
    else $error("page dropped while list not full");

  a_evict_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !is_full && !insert_dropped)
    else $error("list full right after an evict");

  a_no_evict_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page without evict");

endmodule

bind lru_page_order_list_top lpol_checker #(.DEPTH(DEPTH)) u_lpol_checker (.*);
